FILE: rtl/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg
// Types and codes shared by the postfix stack evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pse_pkg;

    localparam int DATA_W       = 32;
    localparam int STEP_W       = $clog2(DATA_W);
    localparam int RESULT_LIMIT = 16;

    // actions
    localparam logic [1:0] ACT_PUSH  = 2'd0;
    localparam logic [1:0] ACT_APPLY = 2'd1;
    localparam logic [1:0] ACT_POP   = 2'd2;
    localparam logic [1:0] ACT_SHOW  = 2'd3;

    // operators
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_REM = 3'd4;

    // status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FEW     = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_DIVZERO = 3'd4;

    typedef struct packed {
        logic [1:0]               action;
        logic [2:0]               operator_code;
        logic signed [DATA_W-1:0] operand_value;
    } cmd_t;

    typedef struct packed {
        logic [2:0]               status;
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } rsp_t;

endpackage

FILE: rtl/postfix_stack_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_stack_evaluator
// Postfix integer evaluator over a bounded stack of signed 32-bit words,
// held in one synchronous RAM with a registered read.
//
//   channel  dir  transfer when          payload
//   cmd      in   cmd_valid & cmd_ready  pse_pkg::cmd_t (action, operator, operand)
//   rsp      out  rsp_valid & rsp_ready  pse_pkg::rsp_t (status, value, last)
//
// One command is worked at a time; cmd_ready is high only while idle.
// Path from accept to the result entering the output register: push, pop,
// empty and short-stack errors take only S_EXEC before it; add/sub/mul and
// the other apply outcomes also read both words and act in S_OP; divide and
// remainder add a 32-step shift-subtract divider; show reads one RAM word per word shown.
// The output register lets a command be accepted while the previous result
// still waits; a stalled rsp holds the sequencer. Reset clears the state, the
// word count and the output valid flag; the RAM needs no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module postfix_stack_evaluator #(
    parameter int STACK_DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  pse_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output pse_pkg::rsp_t rsp
);

    import pse_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int RW = $clog2(RESULT_LIMIT + 1);
    localparam int LW = (CW > RW) ? CW : RW;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_EXEC   = 4'd1;
    localparam logic [3:0] S_RDB    = 4'd2;
    localparam logic [3:0] S_RDA    = 4'd3;
    localparam logic [3:0] S_OP     = 4'd4;
    localparam logic [3:0] S_DIV    = 4'd5;
    localparam logic [3:0] S_DIVFIX = 4'd6;
    localparam logic [3:0] S_SHOW   = 4'd7;
    localparam logic [3:0] S_FINISH = 4'd8;

    logic [DATA_W-1:0] mem [STACK_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;

    logic [3:0]        state_reg,       state_next;
    logic [CW-1:0]     count_reg,       count_next;
    cmd_t              cmd_reg,         cmd_next;
    logic [DATA_W-1:0] a_reg,           a_next;
    logic [DATA_W-1:0] b_reg,           b_next;
    logic [2:0]        pend_status_reg, pend_status_next;
    logic [DATA_W-1:0] pend_value_reg,  pend_value_next;
    logic [RW-1:0]     show_left_reg,   show_left_next;
    logic [AW-1:0]     show_idx_reg,    show_idx_next;
    logic [DATA_W-1:0] divu_reg,        divu_next;
    logic [DATA_W-1:0] quo_reg,         quo_next;
    logic [DATA_W-1:0] rem_reg,         rem_next;
    logic [STEP_W-1:0] step_reg,        step_next;
    logic              negq_reg,        negq_next;
    logic              negr_reg,        negr_next;
    rsp_t              rsp_reg,         rsp_next;
    logic              rsp_valid_reg,   rsp_valid_next;

    logic [CW-1:0]     cnt_m1;
    logic [CW-1:0]     cnt_m2;
    logic [LW-1:0]     show_span;
    logic              out_free;
    logic [DATA_W-1:0] alu_res;
    logic [DATA_W:0]   div_shift;
    logic [DATA_W+1:0] div_diff;
    logic [DATA_W-1:0] quo_fixed;
    logic [DATA_W-1:0] rem_fixed;

    assign cnt_m1    = count_reg - CW'(1);
    assign cnt_m2    = count_reg - CW'(2);
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign show_span = (LW'(count_reg) > LW'(RESULT_LIMIT)) ? LW'(RESULT_LIMIT)
                                                             : LW'(count_reg);

    assign cmd_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        case (cmd_reg.operator_code)
            OP_ADD:  alu_res = a_reg + b_reg;
            OP_SUB:  alu_res = a_reg - b_reg;
            default: alu_res = a_reg * b_reg;
        endcase
    end

    // one restoring divide step on magnitudes
    assign div_shift = {rem_reg, quo_reg[DATA_W-1]};
    assign div_diff  = {1'b0, div_shift} - {2'b00, divu_reg};
    assign quo_fixed = negq_reg ? (DATA_W'(0) - quo_reg) : quo_reg;
    assign rem_fixed = negr_reg ? (DATA_W'(0) - rem_reg) : rem_reg;

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        cmd_next         = cmd_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        pend_status_next = pend_status_reg;
        pend_value_next  = pend_value_reg;
        show_left_next   = show_left_reg;
        show_idx_next    = show_idx_reg;
        divu_next        = divu_reg;
        quo_next         = quo_reg;
        rem_next         = rem_reg;
        step_next        = step_reg;
        negq_next        = negq_reg;
        negr_next        = negr_reg;
        rsp_next         = rsp_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;
        mem_we           = 1'b0;
        mem_waddr        = cnt_m2[AW-1:0];
        mem_wdata        = alu_res;
        mem_re           = 1'b0;
        mem_raddr        = cnt_m1[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                case (cmd_reg.action)
                    ACT_PUSH:
                    begin
                        state_next = S_FINISH;
                        if (count_reg == CW'(STACK_DEPTH))
                        begin
                            pend_status_next = ST_FULL;
                            pend_value_next  = '0;
                        end
                        else
                        begin
                            mem_we           = 1'b1;
                            mem_waddr        = count_reg[AW-1:0];
                            mem_wdata        = cmd_reg.operand_value;
                            count_next       = count_reg + CW'(1);
                            pend_status_next = ST_OK;
                            pend_value_next  = cmd_reg.operand_value;
                        end
                    end
                    ACT_APPLY:
                    begin
                        if (count_reg < CW'(2))
                        begin
                            pend_status_next = ST_FEW;
                            pend_value_next  = '0;
                            state_next       = S_FINISH;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            state_next = S_RDB;
                        end
                    end
                    default:
                    begin
                        // pop is a one-word show that also drops the top
                        if (count_reg == '0)
                        begin
                            pend_status_next = ST_EMPTY;
                            pend_value_next  = '0;
                            state_next       = S_FINISH;
                        end
                        else
                        begin
                            mem_re        = 1'b1;
                            show_idx_next = cnt_m1[AW-1:0];
                            state_next    = S_SHOW;
                            if (cmd_reg.action == ACT_POP)
                            begin
                                show_left_next = RW'(1);
                                count_next     = cnt_m1;
                            end
                            else
                            begin
                                show_left_next = RW'(show_span);
                            end
                        end
                    end
                endcase
            end

            S_RDB:
            begin
                b_next     = rd_data_reg;
                mem_re     = 1'b1;
                mem_raddr  = cnt_m2[AW-1:0];
                state_next = S_RDA;
            end

            S_RDA:
            begin
                a_next     = rd_data_reg;
                state_next = S_OP;
            end

            S_OP:
            begin
                if (cmd_reg.operator_code inside {OP_ADD, OP_SUB, OP_MUL})
                begin
                    mem_we           = 1'b1;
                    count_next       = cnt_m1;
                    pend_status_next = ST_OK;
                    pend_value_next  = alu_res;
                    state_next       = S_FINISH;
                end
                else if (cmd_reg.operator_code inside {OP_DIV, OP_REM})
                begin
                    if (b_reg == '0)
                    begin
                        pend_status_next = ST_DIVZERO;
                        pend_value_next  = '0;
                        state_next       = S_FINISH;
                    end
                    else
                    begin
                        divu_next  = b_reg[DATA_W-1] ? (DATA_W'(0) - b_reg) : b_reg;
                        quo_next   = a_reg[DATA_W-1] ? (DATA_W'(0) - a_reg) : a_reg;
                        rem_next   = '0;
                        step_next  = '0;
                        negq_next  = a_reg[DATA_W-1] ^ b_reg[DATA_W-1];
                        negr_next  = a_reg[DATA_W-1];
                        state_next = S_DIV;
                    end
                end
                else
                begin
                    // unknown operator: stack untouched, plain ok
                    pend_status_next = ST_OK;
                    pend_value_next  = '0;
                    state_next       = S_FINISH;
                end
            end

            S_DIV:
            begin
                if (!div_diff[DATA_W+1])
                begin
                    rem_next = div_diff[DATA_W-1:0];
                    quo_next = {quo_reg[DATA_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = div_shift[DATA_W-1:0];
                    quo_next = {quo_reg[DATA_W-2:0], 1'b0};
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DATA_W - 1))
                begin
                    state_next = S_DIVFIX;
                end
            end

            S_DIVFIX:
            begin
                mem_we           = 1'b1;
                mem_wdata        = (cmd_reg.operator_code == OP_REM) ? rem_fixed : quo_fixed;
                count_next       = cnt_m1;
                pend_status_next = ST_OK;
                pend_value_next  = mem_wdata;
                state_next       = S_FINISH;
            end

            S_SHOW:
            begin
                if (out_free)
                begin
                    rsp_next       = '{status: ST_OK, value: rd_data_reg,
                                       last: (show_left_reg == RW'(1))};
                    rsp_valid_next = 1'b1;
                    if (show_left_reg == RW'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // advance to the next word down
                        show_left_next = show_left_reg - RW'(1);
                        show_idx_next  = show_idx_reg - AW'(1);
                        mem_re         = 1'b1;
                        mem_raddr      = show_idx_reg - AW'(1);
                    end
                end
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    rsp_next       = '{status: pend_status_reg, value: pend_value_reg,
                                       last: 1'b1};
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        a_reg           <= a_next;
        b_reg           <= b_next;
        pend_status_reg <= pend_status_next;
        pend_value_reg  <= pend_value_next;
        show_left_reg   <= show_left_next;
        show_idx_reg    <= show_idx_next;
        divu_reg        <= divu_next;
        quo_reg         <= quo_next;
        rem_reg         <= rem_next;
        step_reg        <= step_next;
        negq_reg        <= negq_next;
        negr_reg        <= negr_next;
        rsp_reg         <= rsp_next;
    end

endmodule

FILE: test/pse_result_checker.sv
// ----------------------------------------------------------------------------
// pse_result_checker
// Watches the command and result channels of the postfix stack evaluator.
// Every command transfer is run through a local copy of the stack, and the
// results it should produce are queued. Each result transfer is compared
// field by field with the oldest queued result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pse_result_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  logic          cmd_ready,
    input  pse_pkg::cmd_t cmd,
    input  logic          rsp_valid,
    input  logic          rsp_ready,
    input  pse_pkg::rsp_t rsp,
    output int            mismatches,
    output int            awaiting,
    output int            checked
);

    import pse_pkg::*;

    localparam int STACK_DEPTH = 16;
    localparam int REPORT_CAP  = 40;

    logic [DATA_W-1:0] words [STACK_DEPTH];
    int                word_count;
    rsp_t              result_q [$];
    rsp_t              oldest;

    task automatic queue_result(input logic [2:0] status, input logic [DATA_W-1:0] value,
                                input logic last);
        rsp_t entry;
        entry.status = status;
        entry.value  = value;
        entry.last   = last;
        result_q.push_back(entry);
    endtask

    // truncate toward zero; the remainder follows the sign of the dividend
    function automatic logic [DATA_W-1:0] trunc_divide(input logic [DATA_W-1:0] num,
                                                        input logic [DATA_W-1:0] den,
                                                        input logic want_rem);
        logic [DATA_W-1:0] mag_n;
        logic [DATA_W-1:0] mag_d;
        logic [DATA_W-1:0] quo;
        logic [DATA_W-1:0] rem;
        mag_n = num[DATA_W-1] ? -num : num;
        mag_d = den[DATA_W-1] ? -den : den;
        quo   = mag_n / mag_d;
        rem   = mag_n % mag_d;
        if (want_rem)
            return num[DATA_W-1] ? -rem : rem;
        return (num[DATA_W-1] ^ den[DATA_W-1]) ? -quo : quo;
    endfunction

    task automatic evaluate_command(input cmd_t c);
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] rhs;
        logic [DATA_W-1:0] res;
        logic              known;
        logic              div_like;
        int                shown;
        case (c.action)
            ACT_PUSH:
            begin
                if (word_count >= STACK_DEPTH)
                    queue_result(ST_FULL, '0, 1'b1);
                else
                begin
                    words[word_count] = c.operand_value;
                    word_count++;
                    queue_result(ST_OK, c.operand_value, 1'b1);
                end
            end
            ACT_APPLY:
            begin
                if (word_count < 2)
                    queue_result(ST_FEW, '0, 1'b1);
                else
                begin
                    rhs      = words[word_count-1];
                    lhs      = words[word_count-2];
                    known    = 1'b1;
                    div_like = (c.operator_code == OP_DIV) || (c.operator_code == OP_REM);
                    res      = '0;
                    case (c.operator_code)
                        OP_ADD: res = lhs + rhs;
                        OP_SUB: res = lhs - rhs;
                        OP_MUL: res = lhs * rhs;
                        OP_DIV, OP_REM:
                            if (rhs != '0)
                                res = trunc_divide(lhs, rhs, c.operator_code == OP_REM);
                        default: known = 1'b0;
                    endcase
                    // unknown operator leaves the stack alone and reports ok
                    if (!known)
                        queue_result(ST_OK, '0, 1'b1);
                    else if (div_like && rhs == '0)
                        queue_result(ST_DIVZERO, '0, 1'b1);
                    else
                    begin
                        word_count--;
                        words[word_count-1] = res;
                        queue_result(ST_OK, res, 1'b1);
                    end
                end
            end
            ACT_POP:
            begin
                if (word_count == 0)
                    queue_result(ST_EMPTY, '0, 1'b1);
                else
                begin
                    word_count--;
                    queue_result(ST_OK, words[word_count], 1'b1);
                end
            end
            default:
            begin
                if (word_count == 0)
                    queue_result(ST_EMPTY, '0, 1'b1);
                else
                begin
                    shown = (word_count > RESULT_LIMIT) ? RESULT_LIMIT : word_count;
                    for (int k = 0; k < shown; k++)
                        queue_result(ST_OK, words[word_count-1-k], k + 1 == shown);
                end
            end
        endcase
    endtask

    task automatic compare_field(input string field, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_count = 0;
            result_q.delete();
            mismatches = 0;
            checked    = 0;
            awaiting   = 0;
        end
        else
        begin
            if (cmd_valid && cmd_ready)
                evaluate_command(cmd);
            if (rsp_valid && rsp_ready)
            begin
                checked++;
                if (result_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_CAP)
                        $display({"%0t: result transfer, expected none, ",
                                  "got status %0d value %0h last %0b"},
                                 $time, rsp.status, rsp.value, rsp.last);
                end
                else
                begin
                    oldest = result_q.pop_front();
                    compare_field("status", DATA_W'(oldest.status), DATA_W'(rsp.status));
                    compare_field("value", oldest.value, rsp.value);
                    compare_field("last", DATA_W'(oldest.last), DATA_W'(rsp.last));
                end
            end
            awaiting = result_q.size();
        end
    end

endmodule

FILE: test/tb_postfix_stack_evaluator.sv
// ----------------------------------------------------------------------------
// tb_postfix_stack_evaluator
// Drives commands into the postfix stack evaluator: a directed run through
// the error cases and arithmetic corners, then bursts of random commands
// whose push rate swings the stack between empty and full. Both channels
// idle at random. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_postfix_stack_evaluator;

    import pse_pkg::*;

    localparam int CYCLE_LIMIT  = 800000;
    // the directed run adds two dozen commands on top of these
    localparam int RANDOM_ITEMS = 386;
    localparam int DRAIN_CYCLES = 60;

    localparam logic signed [DATA_W-1:0] MOST_NEG   = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] MOST_POS   = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [2:0]               OP_UNKNOWN = 3'd5;
    localparam logic [2:0]               OP_TOP     = 3'd7;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_ready;
    cmd_t cmd       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    int mismatches;
    int awaiting;
    int checked;
    int cycles             = 0;
    int sent_by_action [4] = '{default: 0};
    bit sender_eager       = 1'b0;
    bit receiver_eager     = 1'b0;

    always #5 clk = ~clk;

    postfix_stack_evaluator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    pse_result_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .mismatches (mismatches),
        .awaiting   (awaiting),
        .checked    (checked)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still awaited", cycles, awaiting);
            $display("status: fail");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_command(input logic [1:0] act, input logic [2:0] op,
                                input logic signed [DATA_W-1:0] operand);
        int gap;
        gap = sender_eager ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= '{action: act, operator_code: op, operand_value: operand};
        do @(posedge clk); while (!(cmd_valid && cmd_ready));
        @(negedge clk);
        sent_by_action[act]++;
    endtask

    // favor corners and small values so divide by zero and wraps come up often
    function automatic logic signed [DATA_W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 1;
            2:       return -1;
            3:       return MOST_NEG;
            4:       return MOST_POS;
            5, 6, 7: return $signed($urandom_range(0, 40)) - 20;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin : result_sink
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 39) == 0)
                receiver_eager = !receiver_eager;
            gap = receiver_eager ? 0 : $urandom_range(0, 17);
            if (gap > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!(rsp_valid && rsp_ready));
        end
    end

    initial
    begin : stimulus
        int         queued;
        int         push_pct;
        int         burst;
        logic [1:0] act;
        logic [2:0] op;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // errors on an empty or short stack
        send_command(ACT_POP, OP_ADD, '0);
        send_command(ACT_SHOW, OP_ADD, '0);
        send_command(ACT_APPLY, OP_ADD, '0);
        send_command(ACT_PUSH, OP_ADD, MOST_POS);
        send_command(ACT_APPLY, OP_SUB, '0);
        // wrap on add, then most negative over minus one
        send_command(ACT_PUSH, OP_ADD, 1);
        send_command(ACT_APPLY, OP_ADD, '0);
        send_command(ACT_PUSH, OP_ADD, -1);
        send_command(ACT_APPLY, OP_DIV, '0);
        send_command(ACT_PUSH, OP_ADD, -1);
        send_command(ACT_APPLY, OP_REM, '0);
        // unknown operator, divide and remainder by zero
        send_command(ACT_PUSH, OP_ADD, 7);
        send_command(ACT_APPLY, OP_UNKNOWN, '0);
        send_command(ACT_PUSH, OP_ADD, '0);
        send_command(ACT_APPLY, OP_DIV, '0);
        send_command(ACT_APPLY, OP_REM, '0);
        send_command(ACT_POP, OP_ADD, '0);
        // signs of quotient and remainder
        send_command(ACT_PUSH, OP_ADD, -3);
        send_command(ACT_APPLY, OP_REM, '0);
        send_command(ACT_PUSH, OP_ADD, -7);
        send_command(ACT_PUSH, OP_ADD, 2);
        send_command(ACT_APPLY, OP_DIV, '0);
        send_command(ACT_APPLY, OP_MUL, '0);
        send_command(ACT_SHOW, OP_ADD, '0);

        queued = 0;
        while (queued < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 2))
                0:       push_pct = 15;
                1:       push_pct = 50;
                default: push_pct = 85;
            endcase
            sender_eager = ($urandom_range(0, 3) == 0);
            burst        = $urandom_range(10, 40);
            while (burst > 0 && queued < RANDOM_ITEMS)
            begin
                burst--;
                if ($urandom_range(0, 99) < 40)
                begin
                    // two operands and an operator, junk in the unused fields
                    op = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(OP_UNKNOWN, OP_TOP))
                                                     : 3'($urandom_range(OP_ADD, OP_REM));
                    send_command(ACT_PUSH, 3'($urandom), pick_operand());
                    send_command(ACT_PUSH, 3'($urandom), pick_operand());
                    send_command(ACT_APPLY, op, $urandom);
                    queued += 3;
                end
                else
                begin
                    if ($urandom_range(0, 99) < push_pct)
                        act = ACT_PUSH;
                    else
                        case ($urandom_range(0, 2))
                            0:       act = ACT_APPLY;
                            1:       act = ACT_POP;
                            default: act = ACT_SHOW;
                        endcase
                    send_command(act, 3'($urandom), pick_operand());
                    queued++;
                end
            end
        end
        cmd_valid <= 1'b0;

        while (awaiting != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("commands sent: %0d push, %0d apply, %0d pop, %0d show",
                 sent_by_action[ACT_PUSH], sent_by_action[ACT_APPLY],
                 sent_by_action[ACT_POP], sent_by_action[ACT_SHOW]);
        $display("results compared: %0d, field mismatches: %0d", checked, mismatches);
        if (mismatches == 0 && awaiting == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/pse_pkg.sv
rtl/postfix_stack_evaluator.sv
test/pse_result_checker.sv
test/tb_postfix_stack_evaluator.sv
